FILE: hdl/rde_pkg.sv
package rde_pkg;

  localparam int NumberWidth = 32;
  localparam int RadixWidth  = 5;
  localparam int DigitWidth  = 4;
  localparam int CharWidth   = 7;

  localparam logic [RadixWidth-1:0] RadixMin = 5'd2;
  localparam logic [RadixWidth-1:0] RadixMax = 5'd16;

  localparam logic [CharWidth-1:0] CharZero    = 7'h30;
  localparam logic [CharWidth-1:0] CharLetterA = 7'h41;
  localparam logic [CharWidth-1:0] CharNone    = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_RD,
    ST_LD
  } rde_state_t;

  typedef struct packed {
    logic                  digit_valid;
    logic                  last_digit;
    logic [DigitWidth-1:0] digit;
  } rde_div_status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } rde_stack_ctl_t;

  function automatic logic radix_bad(input logic [RadixWidth-1:0] radix);
    return (radix < RadixMin) || (radix > RadixMax);
  endfunction

  // Floor of log2 for a legal radix: each division shortens the value by this many bits.
  function automatic logic [2:0] radix_log2(input logic [RadixWidth-1:0] radix);
    logic [2:0] lg;
    if (radix[4]) begin
      lg = 3'd4;
    end else if (radix[3]) begin
      lg = 3'd3;
    end else if (radix[2]) begin
      lg = 3'd2;
    end else begin
      lg = 3'd1;
    end
    return lg;
  endfunction

  function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d < 4'd10) begin
      c = CharZero + CharWidth'(d);
    end else begin
      c = CharLetterA + CharWidth'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

FILE: hdl/rde_in_if.sv
interface rde_in_if;
  import rde_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [NumberWidth-1:0] number;
  logic [RadixWidth-1:0]  radix;

  modport source (output valid, output number, output radix, input ready);
  modport sink   (input valid, input number, input radix, output ready);
endinterface

FILE: hdl/rde_out_if.sv
interface rde_out_if;
  import rde_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_code;
  logic                 bad_radix;
  logic                 last;

  modport source (output valid, output char_code, output bad_radix, output last, input ready);
  modport sink   (input valid, input char_code, input bad_radix, input last, output ready);
endinterface

FILE: hdl/rde_divider.sv
module rde_divider
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int START_LEN   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] start_value,
  input  logic [RadixWidth-1:0]  radix,
  output rde_div_status_t        status
);

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam int LW = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic [VALUE_WIDTH-1:0] val;
  logic [DigitWidth-1:0]  rem;
  logic [RadixWidth-1:0]  radix_q;
  logic [CW-1:0]          cnt;
  logic [LW-1:0]          len;

  logic [RadixWidth-1:0]  trial;
  logic                   take;
  logic [RadixWidth-1:0]  rem_step;
  logic [VALUE_WIDTH-1:0] val_step;
  logic [LW-1:0]          len_next;
  logic [LW-1:0]          cnt_wide;
  logic                   pass_end;
  logic                   quot_zero;

  // One restoring step per cycle; the quotient bit replaces the dividend bit in place.
  always_comb begin
    trial     = {rem, val[cnt]};
    take      = (trial >= radix_q);
    rem_step  = take ? (trial - radix_q) : trial;
    val_step  = val;
    val_step[cnt] = take;
    len_next  = len - LW'(radix_log2(radix_q));
    cnt_wide  = len_next - LW'(1);
    pass_end  = busy && (cnt == '0);
    quot_zero = (val_step == '0);

    status.digit_valid = pass_end;
    status.last_digit  = pass_end && quot_zero;
    status.digit       = rem_step[DigitWidth-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (pass_end && quot_zero) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val     <= start_value;
      rem     <= '0;
      radix_q <= radix;
      len     <= LW'(START_LEN);
      cnt     <= CW'(START_LEN - 1);
    end else if (busy) begin
      val <= val_step;
      if (cnt == '0) begin
        rem <= '0;
        len <= len_next;
        cnt <= cnt_wide[CW-1:0];
      end else begin
        rem <= rem_step[DigitWidth-1:0];
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/rde_stack.sv
module rde_stack
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rde_stack_ctl_t        ctl,
  input  logic [DigitWidth-1:0] push_data,
  output logic [DigitWidth-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int LW = $clog2(VALUE_WIDTH + 1);

  logic [DigitWidth-1:0] mem [VALUE_WIDTH];
  logic [LW-1:0]         sp;
  logic [LW-1:0]         sp_dec;

  assign sp_dec = sp - LW'(1);
  assign empty  = (sp == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctl.push) begin
      sp <= sp + LW'(1);
    end else if (ctl.pop) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[sp[AW-1:0]] <= push_data;
    end
    if (ctl.pop) begin
      rd_data <= mem[sp_dec[AW-1:0]];
    end
  end

endmodule

FILE: hdl/radix_digit_emitter_top.sv
// Converts an unsigned number to its digits in a radix from 2 to 16 and sends them out most
// significant first, one beat per digit, as upper-case ASCII characters, with last set on the
// final digit. A zero number gives the single digit '0'. A radix outside 2 to 16 gives one
// beat with bad_radix and last set and a char_code of zero. Only the low VALUE_WIDTH bits of
// number are converted. Digits are produced by a bit-serial restoring divider that handles
// one bit of the value per cycle, least significant digit first, and are parked in a small
// digit stack so they can be sent back out in reverse order. The first division pass covers
// min(VALUE_WIDTH, 32) bits; each following pass is shorter by floor(log2(radix)) bits.
// Each digit then goes through the stack read port: it is popped in ST_RD once the output
// register is free and loaded into it in ST_LD. One number is converted at a time; the
// next one is taken as soon as the last digit of the current one sits in the output
// register, even while that beat still waits to be taken.
module radix_digit_emitter_top
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  rde_in_if.sink     din,
  rde_out_if.source  dout
);

  // Only the bits that the input field actually carries take part in the first pass.
  localparam int LoadW = (VALUE_WIDTH < NumberWidth) ? VALUE_WIDTH : NumberWidth;

  rde_state_t       state;
  rde_state_t       state_next;
  rde_div_status_t  div_status;
  rde_stack_ctl_t   stk_ctl;
  logic             div_start;
  logic [DigitWidth-1:0] stk_rd;
  logic             stk_empty;
  logic             out_free;
  logic             load_err;
  logic             load_digit;

  logic                 out_valid;
  logic [CharWidth-1:0] out_char;
  logic                 out_bad;
  logic                 out_last;

  rde_divider #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .START_LEN   (LoadW)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .start_value (VALUE_WIDTH'(din.number[LoadW-1:0])),
    .radix       (din.radix),
    .status      (div_status)
  );

  rde_stack #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (stk_ctl),
    .push_data (div_status.digit),
    .rd_data   (stk_rd),
    .empty     (stk_empty)
  );

  // The output register is free when it is empty or its beat leaves this cycle.
  assign out_free = !out_valid || dout.ready;

  assign din.ready      = (state == ST_IDLE);
  assign dout.valid     = out_valid;
  assign dout.char_code = out_char;
  assign dout.bad_radix = out_bad;
  assign dout.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    stk_ctl.push = div_status.digit_valid;
    stk_ctl.pop  = 1'b0;
    load_err     = 1'b0;
    load_digit   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (din.valid) begin
          if (radix_bad(din.radix)) begin
            state_next = ST_ERR;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load_err   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        // Digits are pushed as each pass ends; the pass whose quotient is zero is the last.
        if (div_status.last_digit) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (out_free) begin
          stk_ctl.pop = 1'b1;
          state_next  = ST_LD;
        end
      end
      ST_LD: begin
        // The stack read data is valid now; an empty stack means this is the bottom, least significant digit.
        load_digit = 1'b1;
        state_next = stk_empty ? ST_IDLE : ST_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_err || load_digit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_err) begin
      out_char <= CharNone;
      out_bad  <= 1'b1;
      out_last <= 1'b1;
    end else if (load_digit) begin
      out_char <= digit_char(stk_rd);
      out_bad  <= 1'b0;
      out_last <= stk_empty;
    end
  end

endmodule

FILE: tb/tb.sv
module tb;
  import rde_pkg::*;

  // One conversion request as the driver offers it. When drain_first is set, the driver
  // holds this beat back until every digit still owed by the block has come out.
  typedef struct {
    logic [NumberWidth-1:0] number;
    logic [RadixWidth-1:0]  radix;
    bit                     drain_first;
  } conv_req_t;

  // One output beat as the block should send it.
  typedef struct {
    logic [CharWidth-1:0] char_code;
    logic                 bad_radix;
    logic                 last;
  } digit_beat_t;

  localparam int    RandomReqs  = 500;
  localparam int    QuietTail   = 60;    // the final requests run with no idling at all
  localparam int    LongHoldAt  = 150;   // input beats taken before the long sink hold-off
  localparam int    LongHoldLen = 2000;
  localparam int    SettleLen   = 600;   // a little more than one full radix-2 division
  localparam string DigitSet    = "0123456789ABCDEF";

  logic clk;
  logic rst;

  rde_in_if  din_if ();
  rde_out_if dout_if ();

  radix_digit_emitter_top #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  conv_req_t   pending[$];     // requests not yet offered to the block
  digit_beat_t digits_due[$];  // digits the block still owes, oldest first

  int          errors      = 0;
  int          in_beats    = 0;
  int          out_beats   = 0;
  int          total_reqs  = 1 << 30;
  int unsigned cyc         = 0;
  logic        in_took     = 1'b0;
  int          src_gap     = 0;
  int          sink_gap    = 0;
  int          hold_left   = 0;
  bit          long_held   = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The tail of the run is free of idling, and so is every third stretch of the cycle counter,
  // so that back-to-back beats get exercised between the bursty stretches.
  function automatic bit idling_off();
    return (in_beats + QuietTail >= total_reqs) || ((cyc / 400) % 3 == 2);
  endfunction

  // Works out the beats one request should produce and queues them. An out-of-range
  // radix gives one flagged beat regardless of the number; a zero number gives a
  // single '0'. Otherwise the digits are found least significant first by repeated
  // division and then queued in the opposite order, most significant first.
  function automatic void predict_digits(input logic [NumberWidth-1:0] num,
                                         input logic [RadixWidth-1:0]  rad);
    logic [NumberWidth-1:0] rest;
    int unsigned            base;
    int unsigned            rev[$];
    digit_beat_t            beat;
    rest = num;
    base = 32'(rad);
    if (rad < RadixMin || rad > RadixMax) begin
      beat = '{char_code: CharNone, bad_radix: 1'b1, last: 1'b1};
      digits_due.push_back(beat);
    end else if (num == '0) begin
      beat = '{char_code: CharZero, bad_radix: 1'b0, last: 1'b1};
      digits_due.push_back(beat);
    end else begin
      while (rest != '0) begin
        rev.push_back(rest % base);
        rest = rest / base;
      end
      for (int k = rev.size() - 1; k >= 0; k--) begin
        beat.char_code = CharWidth'(DigitSet[rev[k]]);
        beat.bad_radix = 1'b0;
        beat.last      = (k == 0);
        digits_due.push_back(beat);
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("output beat %0d: %s", out_beats, what);
    end
    errors++;
  endtask

  task automatic add_req(input logic [NumberWidth-1:0] num, input logic [RadixWidth-1:0] rad,
                         input bit drain);
    conv_req_t r;
    r.number      = num;
    r.radix       = rad;
    r.drain_first = drain;
    pending.push_back(r);
  endtask

  // Input side: a beat is taken at a rising edge with valid and ready both high, and its
  // expected digits are queued right then. in_took tells the driver at the following
  // falling edge that the beat it was holding is gone.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    in_took <= !rst && din_if.valid && din_if.ready;
    if (!rst && din_if.valid && din_if.ready) begin
      predict_digits(din_if.number, din_if.radix);
      in_beats++;
    end
  end

  // Driver. A beat once offered stays put until it is taken; only between beats may the
  // sender go quiet, either for a random burst or, for a request marked drain_first,
  // until the block has sent everything it owes.
  always @(negedge clk) begin
    logic next_valid;
    next_valid = din_if.valid && !in_took;
    if (!rst && !next_valid) begin
      if (src_gap == 0 && !idling_off() && $urandom_range(0, 3) == 0) begin
        src_gap = $urandom_range(1, 8);
      end
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending.size() != 0 &&
                   (!pending[0].drain_first || digits_due.size() == 0)) begin
        din_if.number <= pending[0].number;
        din_if.radix  <= pending[0].radix;
        next_valid = 1'b1;
        void'(pending.pop_front());
      end
    end
    din_if.valid <= next_valid;
  end

  // Sink readiness. Once, after a fair number of input beats, the sink holds ready low
  // for a long stretch while the driver keeps offering, so that the block backs up all
  // the way to its input. Otherwise ready drops in random bursts outside the quiet parts.
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b1;
    if (rst) begin
      next_ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (!long_held && in_beats >= LongHoldAt) begin
      long_held = 1'b1;
      hold_left = LongHoldLen - 1;
      next_ready = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      next_ready = 1'b0;
    end else if (!idling_off() && $urandom_range(0, 4) == 0) begin
      sink_gap = $urandom_range(1, 8) - 1;
      next_ready = 1'b0;
    end
    dout_if.ready <= next_ready;
  end

  // Monitor: every output beat is checked field by field against the oldest expectation.
  always @(posedge clk) begin
    digit_beat_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (digits_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char=%0h bad=%0b last=%0b",
                                  dout_if.char_code, dout_if.bad_radix, dout_if.last));
      end else begin
        want = digits_due.pop_front();
        if (dout_if.char_code !== want.char_code) begin
          report_mismatch($sformatf("char_code %0h, expected %0h",
                                    dout_if.char_code, want.char_code));
        end
        if (dout_if.bad_radix !== want.bad_radix) begin
          report_mismatch($sformatf("bad_radix %0b, expected %0b",
                                    dout_if.bad_radix, want.bad_radix));
        end
        if (dout_if.last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", dout_if.last, want.last));
        end
      end
      out_beats++;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [NumberWidth-1:0] num;
    logic [RadixWidth-1:0]  rad;
    rst           = 1'b1;
    din_if.valid  = 1'b0;
    din_if.number = '0;
    din_if.radix  = '0;
    dout_if.ready = 1'b0;

    // Directed part. Radices just outside the legal range and at the top of the field
    // must be flagged, even with a zero number. The all-ones value is converted in every
    // legal radix, which also gives the longest digit strings. A zero number must give a
    // lone '0'. A few values land on the digit boundaries between '9' and 'A'.
    add_req(32'd12345, 5'd0, 1'b0);
    add_req(32'hFFFF_FFFF, 5'd1, 1'b0);
    add_req(32'd77, 5'd17, 1'b0);
    add_req(32'h8000_0001, 5'd31, 1'b0);
    add_req(32'd0, 5'd0, 1'b0);
    for (int r = 2; r <= 16; r++) begin
      add_req(32'hFFFF_FFFF, RadixWidth'(r), 1'b0);
    end
    add_req(32'd0, 5'd2, 1'b0);
    add_req(32'd0, 5'd16, 1'b0);
    add_req(32'h0ABC_DEF9, 5'd16, 1'b0);
    add_req(32'h8000_0000, 5'd2, 1'b0);

    // Random part. Numbers are drawn from several shapes, since short values exercise
    // the one-digit path and powers of two hit every single bit. Most radices are legal;
    // the rest span the whole field. Twice along the way the sender waits for the block
    // to empty completely before offering more.
    for (int i = 0; i < RandomReqs; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: num = $urandom();
        4, 5:       num = $urandom_range(0, 255);
        6:          num = 32'd1 << $urandom_range(0, 31);
        7:          num = (32'd1 << $urandom_range(0, 31)) - 32'd1;
        8:          num = 32'hFFFF_FFFF - $urandom_range(0, 15);
        default:    num = $urandom_range(0, 1);
      endcase
      if ($urandom_range(0, 6) == 0) begin
        rad = RadixWidth'($urandom_range(0, 31));
      end else begin
        rad = RadixWidth'($urandom_range(2, 16));
      end
      add_req(num, rad, (i == 200) || (i == 400));
    end
    total_reqs = pending.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (in_beats < total_reqs) @(negedge clk);
    while (digits_due.size() != 0) @(negedge clk);
    // Leave room for any stray beat the block might still send.
    repeat (SettleLen) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond a run where every request is a full radix-2 conversion with
  // every digit stalled at the sink.
  initial begin
    #25_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
